// ----- src/stick_cartesian_to_polar_defines.svh -----
// assertion macros shared by the stick_cartesian_to_polar checkers
// expects signals named aclk and aresetn in the scope of use
`ifndef STICK_CARTESIAN_TO_POLAR_DEFINES_SVH
`define STICK_CARTESIAN_TO_POLAR_DEFINES_SVH

// clocked check, masked while reset is asserted
`define SCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also runs through reset
`define SCP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/scp_pkg.sv -----
// types and constants for the stick_cartesian_to_polar cordic datapath
// no dependencies
`default_nettype none

package scp_pkg;

    // vector components carry 31 fraction bits, angles 30 fraction bits
    localparam int ZW         = 34;
    localparam int ATAN_COUNT = 24;

    localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic        [31:0]   GAIN_INV_Q32 = 32'd2608131496;
    localparam logic        [16:0]   MAG_MAX      = 17'd46341;
    localparam logic signed [17:0]   ANGLE_MAX    = 18'sd25736;

    // atan(2^-i) scaled by 2^30, rounded
    localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_COUNT] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    // one sample in flight through the rotation stages
    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [15:0]   xi;
        logic                 zero;
    } item_t;

endpackage

`default_nettype wire

// ----- src/scp_cordic_stage.sv -----
// one registered cordic vectoring micro-rotation
// depends on scp_pkg
`default_nettype none

module scp_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire scp_pkg::item_t in_item,
    output logic                out_valid,
    output scp_pkg::item_t      out_item
);

    logic                          valid_reg;
    scp_pkg::item_t                item_reg;
    scp_pkg::item_t                item_next;
    logic signed [scp_pkg::ZW-1:0] dx;
    logic signed [scp_pkg::ZW-1:0] dy;

    assign dx = in_item.x >>> STAGE;
    assign dy = in_item.y >>> STAGE;

    always_comb begin
        item_next = in_item;
        if (!in_item.y[scp_pkg::ZW-1]) begin
            item_next.x = in_item.x + dy;
            item_next.y = in_item.y - dx;
            item_next.z = in_item.z + scp_pkg::ATAN_Q30[STAGE];
        end else begin
            item_next.x = in_item.x - dy;
            item_next.y = in_item.y + dx;
            item_next.z = in_item.z - scp_pkg::ATAN_Q30[STAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- src/stick_cartesian_to_polar.sv -----
// stick_cartesian_to_polar: throughput one transaction per cycle; the pipeline moves only when the output is free
// stages: input fold, one per micro-rotation, gain partial products, sum and clamp
// reset (aresetn, synchronous) clears all valid bits; payload registers are not reset
// depends on scp_pkg and scp_cordic_stage
`default_nettype none

module stick_cartesian_to_polar #(
    parameter int ITERATIONS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input transaction
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_x_raw,
    input  wire logic signed [15:0] s_y_raw,
    // result transaction
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_x_inverted,
    output logic        [15:0]      m_magnitude,
    output logic signed [15:0]      m_angle
);

    // micro-rotations past the table length add nothing
    localparam int ITER_N = (ITERATIONS > scp_pkg::ATAN_COUNT) ?
                            scp_pkg::ATAN_COUNT : ITERATIONS;
    localparam int ZW     = scp_pkg::ZW;

    // whole pipeline advances together whenever the output slot frees up
    logic en;

    // ---------------- input fold stage ----------------
    logic signed [15:0]   xi_next;
    logic signed [ZW-1:0] xs;
    logic signed [ZW-1:0] ys;
    scp_pkg::item_t       in_next;
    scp_pkg::item_t       in_reg;
    logic                 in_valid_reg;

    always_comb begin
        // negate x, most negative value saturates
        xi_next = (s_x_raw == 16'sh8000) ? 16'sh7FFF : -s_x_raw;
        // Q1.15 to 31 fraction bits
        xs = {{2{xi_next[15]}}, xi_next, 16'h0000};
        ys = {{2{s_y_raw[15]}}, s_y_raw, 16'h0000};
        in_next.xi   = xi_next;
        in_next.zero = (xi_next == 16'sd0) && (s_y_raw == 16'sd0);
        if (xi_next[15]) begin
            // left half plane: turn by pi first
            in_next.x = -xs;
            in_next.y = -ys;
            in_next.z = s_y_raw[15] ? -scp_pkg::PI_Q30 : scp_pkg::PI_Q30;
        end else begin
            in_next.x = xs;
            in_next.y = ys;
            in_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
        if (en) begin
            in_reg <= in_next;
        end
    end

    // ---------------- rotation stages ----------------
    logic           rot_valid [ITER_N+1];
    scp_pkg::item_t rot_item  [ITER_N+1];

    assign rot_valid[0] = in_valid_reg;
    assign rot_item[0]  = in_reg;

    for (genvar g = 0; g < ITER_N; g++) begin : g_rot
        scp_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (rot_valid[g]),
            .in_item   (rot_item[g]),
            .out_valid (rot_valid[g+1]),
            .out_item  (rot_item[g+1])
        );
    end

    scp_pkg::item_t rot_last;
    assign rot_last = rot_item[ITER_N];

    // ---------------- gain partial products and angle ----------------
    // x is split 16/17 bits so each product stays within a 32-bit multiplier
    logic        [32:0]   xc;
    logic        [48:0]   pp_lo_next;
    logic        [47:0]   pp_hi_next;
    logic signed [ZW:0]   z_round;
    logic signed [17:0]   ang_full;
    logic signed [15:0]   ang_next;
    logic        [48:0]   pp_lo_reg;
    logic        [47:0]   pp_hi_reg;
    logic signed [15:0]   ang_reg;
    logic signed [15:0]   mul_xi_reg;
    logic                 mul_zero_reg;
    logic                 mul_valid_reg;

    always_comb begin
        xc = rot_last.x[ZW-1] ? 33'd0 : rot_last.x[32:0];
        pp_lo_next = {32'd0, xc[16:0]} * {17'd0, scp_pkg::GAIN_INV_Q32};
        pp_hi_next = {32'd0, xc[32:17]} * {16'd0, scp_pkg::GAIN_INV_Q32};
        // round the angle to Q3.13 and clamp to +-pi
        z_round  = {rot_last.z[ZW-1], rot_last.z} + 35'sd65536;
        ang_full = 18'(z_round >>> 17);
        if (rot_last.zero) begin
            ang_next = 16'sd0;
        end else if (ang_full > scp_pkg::ANGLE_MAX) begin
            ang_next = 16'(scp_pkg::ANGLE_MAX);
        end else if (ang_full < -scp_pkg::ANGLE_MAX) begin
            ang_next = 16'(-scp_pkg::ANGLE_MAX);
        end else begin
            ang_next = ang_full[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= rot_valid[ITER_N];
        end
        if (en) begin
            pp_lo_reg    <= pp_lo_next;
            pp_hi_reg    <= pp_hi_next;
            ang_reg      <= ang_next;
            mul_xi_reg   <= rot_last.xi;
            mul_zero_reg <= rot_last.zero;
        end
    end

    // ---------------- magnitude sum, round and clamp ----------------
    logic [64:0] prod_round;
    logic [16:0] mag_full;
    logic [15:0] mag_next;

    always_comb begin
        prod_round = {pp_hi_reg, 17'd0} + {16'd0, pp_lo_reg} + (65'd1 << 47);
        mag_full   = prod_round[64:48];
        if (mul_zero_reg) begin
            mag_next = 16'd0;
        end else if (mag_full > scp_pkg::MAG_MAX) begin
            mag_next = scp_pkg::MAG_MAX[15:0];
        end else begin
            mag_next = mag_full[15:0];
        end
    end

    // ---------------- output register ----------------
    logic               m_valid_reg;
    logic signed [15:0] x_inverted_reg;
    logic        [15:0] magnitude_reg;
    logic signed [15:0] angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mul_valid_reg;
        end
        if (en) begin
            x_inverted_reg <= mul_xi_reg;
            magnitude_reg  <= mag_next;
            angle_reg      <= ang_reg;
        end
    end

    // a held result stalls every stage; an empty output slot never does
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign m_valid      = m_valid_reg;
    assign m_x_inverted = x_inverted_reg;
    assign m_magnitude  = magnitude_reg;
    assign m_angle      = angle_reg;

endmodule

`default_nettype wire

// ----- src/scp_checker.sv -----
// port-level checks for stick_cartesian_to_polar, bound to the top level
// depends on stick_cartesian_to_polar_defines.svh and stick_cartesian_to_polar
`default_nettype none
`include "stick_cartesian_to_polar_defines.svh"

module scp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic signed [15:0] s_x_raw,
    input wire logic signed [15:0] s_y_raw,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_x_inverted,
    input wire logic        [15:0] m_magnitude,
    input wire logic signed [15:0] m_angle
);

    // a stalled result transaction holds
    `SCP_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_x_inverted) && $stable(m_magnitude) && $stable(m_angle), "result changed while stalled")

    // an empty output slot never blocks input
    `SCP_ASSERT(a_ready, !m_valid |-> s_ready, "input stalled with empty output")

    // results stay inside their clamped ranges
    `SCP_ASSERT(a_range, m_valid |-> (m_magnitude <= 16'd46341) && (m_angle <= 16'sd25736) && (m_angle >= -16'sd25736) && (m_x_inverted != 16'sh8000), "result out of range")

    // reset empties the pipeline
    `SCP_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind stick_cartesian_to_polar scp_checker u_scp_checker (.*);

`default_nettype wire
